>>> sv/mfbp_pkg.sv
// ---------------------------------------------------------------------------
// mfbp_pkg: shared types and constants for the MSB-first bit packer
// Command codes, field widths and stream bus widths.
// ---------------------------------------------------------------------------
package mfbp_pkg;

   // field widths
   localparam int WORD_BITS  = 64;
   localparam int CMD_W      = 2;
   localparam int OFFSET_W   = 6;
   localparam int COUNT_W    = 7;
   localparam int BYTE_W     = 8;
   localparam int MBITS_W    = 4;

   // stream bus widths (fields packed from bit 0, padded to whole bytes)
   localparam int REQ_FIELDS_W = WORD_BITS + OFFSET_W + COUNT_W;
   localparam int REQ_TDATA_W  = ((REQ_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_FIELDS_W = BYTE_W + MBITS_W;
   localparam int RSP_TDATA_W  = ((RSP_FIELDS_W + 7) / 8) * 8;
   localparam int REQ_TUSER_W  = CMD_W;

   // full byte marker for meaningful_bits
   localparam logic [MBITS_W-1:0] FULL_BYTE_BITS = MBITS_W'(BYTE_W);

   // command codes
   typedef logic [CMD_W-1:0] cmd_type;
   localparam cmd_type CMD_APPEND_DATA = 2'd0;
   localparam cmd_type CMD_APPEND_ZERO = 2'd1;
   localparam cmd_type CMD_FLUSH       = 2'd2;

endpackage

>>> sv/msb_first_bit_packer.sv
// ---------------------------------------------------------------------------
// msb_first_bit_packer: variable-length MSB-first bit packer
// Packs data chunks, zero runs and flushes into a byte stream.
// ---------------------------------------------------------------------------
// Usage:
//   Request channel (req_*): one command per request. req_tuser carries the
//   command (append data, append zeros, flush); req_tdata carries the source
//   word, the bit offset and the bit count.
//   Response channel (rsp_*): one completed byte per transfer with its count
//   of meaningful bits; rsp_tlast marks the last byte caused by a request.
//   A request that completes no byte produces no response.
// Path: a request passes the request register, the byte drain and the
//   output register before its first byte appears.
// Throughput: the drain sends one byte per cycle while rsp_tready allows
//   (up to eight per request for a 64-bit chunk); a request that completes
//   at most one byte lets the next one in the following cycle if not stalled.
// Reset: the pending partial byte and its fill level clear, all stages empty.
// Stall: when rsp_tready is low the output register holds; the drain and the
//   request register fill up and req_tready drops once both are occupied.
// ---------------------------------------------------------------------------
module msb_first_bit_packer #(
   parameter int CHUNK_BITS = 64
) (
   input  logic                             clock,
   input  logic                             reset,
   // request channel
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // tdata: chunk_word[63:0], bit_offset[69:64], bit_count[76:70], zero pad
   input  logic [mfbp_pkg::REQ_TDATA_W-1:0] req_tdata,
   // tuser: cmd[1:0]
   input  logic [mfbp_pkg::REQ_TUSER_W-1:0] req_tuser,
   // response channel
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // tdata: out_byte[7:0], meaningful_bits[11:8], zero pad
   output logic [mfbp_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   output logic                             rsp_tlast
);

   localparam int BUF_W     = CHUNK_BITS + mfbp_pkg::BYTE_W;
   localparam int MAX_BYTES = (CHUNK_BITS + 7) / 8;
   localparam int NB_W      = $clog2(MAX_BYTES + 1);
   localparam int TOT_W     = $clog2(CHUNK_BITS + 8);
   localparam int BYTE_W    = mfbp_pkg::BYTE_W;
   localparam int MBITS_W   = mfbp_pkg::MBITS_W;
   localparam int COUNT_W   = mfbp_pkg::COUNT_W;
   localparam int OFFSET_W  = mfbp_pkg::OFFSET_W;
   localparam int WORD_BITS = mfbp_pkg::WORD_BITS;

   // request register
   logic                      in_valid_ff;
   mfbp_pkg::cmd_type         in_cmd_ff;
   logic [WORD_BITS-1:0]      in_word_ff;
   logic [OFFSET_W-1:0]       in_offset_ff;
   logic [COUNT_W-1:0]        in_count_ff;

   // pending partial byte
   logic [BYTE_W-1:0]         pending_byte_ff, pending_byte_in;
   logic [2:0]                pending_fill_ff, pending_fill_in;
   logic                      pending_upd;

   // byte drain register
   logic                      work_valid_ff;
   logic [BUF_W-1:0]          work_buf_ff, work_buf_in;
   logic [NB_W-1:0]           work_rem_ff, work_rem_in;
   logic [MBITS_W-1:0]        work_tail_ff, work_tail_in;

   // output register
   logic                      rsp_valid_ff;
   logic [BYTE_W-1:0]         rsp_byte_ff;
   logic [MBITS_W-1:0]        rsp_bits_ff;
   logic                      rsp_last_ff;

   // handshake
   logic                      rsp_load;
   logic                      work_emit;
   logic                      work_last;
   logic                      work_free;
   logic                      in_move;

   // chunk alignment
   logic [CHUNK_BITS-1:0]     src;
   logic [CHUNK_BITS-1:0]     aligned;
   logic [CHUNK_BITS-1:0]     masked;
   logic [COUNT_W-1:0]        avail;
   logic [COUNT_W-1:0]        cnt;
   logic [BUF_W-1:0]          ext;
   logic [BUF_W-1:0]          comb_buf;
   logic [BUF_W-1:0]          rest;
   logic [TOT_W-1:0]          total;
   logic [NB_W-1:0]           nbytes;

   assign rsp_load   = !rsp_valid_ff || rsp_tready;
   assign work_emit  = work_valid_ff && rsp_load;
   assign work_last  = (work_rem_ff == NB_W'(1));
   assign work_free  = !work_valid_ff || (work_emit && work_last);
   assign in_move    = in_valid_ff && work_free;
   assign req_tready = !in_valid_ff || in_move;

   // clip the count and left-align the chunk bits
   always_comb begin
      src   = in_word_ff[CHUNK_BITS-1:0];
      avail = ({1'b0, in_offset_ff} < COUNT_W'(CHUNK_BITS)) ?
              COUNT_W'(CHUNK_BITS) - COUNT_W'(in_offset_ff) : '0;
      case (in_cmd_ff)
         mfbp_pkg::CMD_APPEND_DATA: begin
            cnt = (in_count_ff > avail) ? avail : in_count_ff;
         end
         mfbp_pkg::CMD_APPEND_ZERO: begin
            cnt = (in_count_ff > COUNT_W'(CHUNK_BITS)) ? COUNT_W'(CHUNK_BITS) : in_count_ff;
         end
         default: begin
            cnt = '0;
         end
      endcase
      aligned = src << in_offset_ff;
      if (in_cmd_ff == mfbp_pkg::CMD_APPEND_DATA) begin
         masked = aligned & ~({CHUNK_BITS{1'b1}} >> cnt);
      end else begin
         masked = '0;
      end
   end

   // merge with the pending byte, count completed bytes, split off the tail
   always_comb begin
      ext      = {masked, {BYTE_W{1'b0}}} >> pending_fill_ff;
      comb_buf = {pending_byte_ff, {CHUNK_BITS{1'b0}}} | ext;
      total    = TOT_W'(pending_fill_ff) + TOT_W'(cnt);
      nbytes   = NB_W'(total >> 3);
      rest     = comb_buf << {nbytes, 3'b000};

      work_buf_in     = comb_buf;
      work_rem_in     = nbytes;
      work_tail_in    = mfbp_pkg::FULL_BYTE_BITS;
      pending_byte_in = rest[BUF_W-1 -: BYTE_W];
      pending_fill_in = total[2:0];
      pending_upd     = 1'b1;

      case (in_cmd_ff) inside
         mfbp_pkg::CMD_APPEND_DATA, mfbp_pkg::CMD_APPEND_ZERO: begin
         end
         mfbp_pkg::CMD_FLUSH: begin
            work_rem_in     = (pending_fill_ff != 3'd0) ? NB_W'(1) : '0;
            work_tail_in    = MBITS_W'(pending_fill_ff);
            pending_byte_in = '0;
            pending_fill_in = '0;
         end
         default: begin
            work_rem_in = '0;
            pending_upd = 1'b0;
         end
      endcase
   end

   // request register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
      if (req_tready && req_tvalid) begin
         in_cmd_ff    <= req_tuser[mfbp_pkg::CMD_W-1:0];
         in_word_ff   <= req_tdata[WORD_BITS-1:0];
         in_offset_ff <= req_tdata[WORD_BITS +: OFFSET_W];
         in_count_ff  <= req_tdata[WORD_BITS+OFFSET_W +: COUNT_W];
      end
   end

   // pending state advances as each data, zero or flush request enters the drain
   always_ff @(posedge clock) begin
      if (reset) begin
         pending_byte_ff <= '0;
         pending_fill_ff <= '0;
      end else if (in_move && pending_upd) begin
         pending_byte_ff <= pending_byte_in;
         pending_fill_ff <= pending_fill_in;
      end
   end

   // byte drain: load a new request or shift out one byte per cycle while the output register can take it
   always_ff @(posedge clock) begin
      if (reset) begin
         work_valid_ff <= 1'b0;
      end else if (in_move) begin
         work_valid_ff <= (work_rem_in != '0);
      end else if (work_emit && work_last) begin
         work_valid_ff <= 1'b0;
      end
      if (in_move) begin
         work_buf_ff  <= work_buf_in;
         work_rem_ff  <= work_rem_in;
         work_tail_ff <= work_tail_in;
      end else if (work_emit) begin
         work_buf_ff <= work_buf_ff << BYTE_W;
         work_rem_ff <= work_rem_ff - NB_W'(1);
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= work_valid_ff;
      end
      if (work_emit) begin
         rsp_byte_ff <= work_buf_ff[BUF_W-1 -: BYTE_W];
         rsp_bits_ff <= work_last ? work_tail_ff : mfbp_pkg::FULL_BYTE_BITS;
         rsp_last_ff <= work_last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(mfbp_pkg::RSP_TDATA_W - mfbp_pkg::RSP_FIELDS_W){1'b0}},
                        rsp_bits_ff, rsp_byte_ff};
   assign rsp_tlast  = rsp_last_ff;

   // bits below the fill level of the partial byte stay clear
   a_pending_clean: assert property (@(posedge clock) disable iff (reset)
      (pending_byte_ff & (8'hFF >> pending_fill_ff)) == 8'h00)
      else $error("pending byte has bits below its fill level");

   // an occupied drain always has bytes left to send
   a_work_rem: assert property (@(posedge clock) disable iff (reset)
      work_valid_ff |-> (work_rem_ff != '0) && (work_rem_ff <= NB_W'(MAX_BYTES)))
      else $error("byte drain occupied with no bytes left");

   // only the last byte of a request may be partial
   a_partial_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_last_ff |-> rsp_bits_ff == mfbp_pkg::FULL_BYTE_BITS)
      else $error("partial byte not marked last");

   // a response never carries an empty or oversized byte
   a_bits_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_bits_ff != '0) && (rsp_bits_ff <= mfbp_pkg::FULL_BYTE_BITS))
      else $error("meaningful bit count out of range");

   // a flush always leaves nothing pending
   a_flush_clears: assert property (@(posedge clock) disable iff (reset)
      in_move && (in_cmd_ff == mfbp_pkg::CMD_FLUSH) |=> pending_fill_ff == 3'd0)
      else $error("flush left pending bits");

endmodule

>>> tb/sv/testbench.sv
// ---------------------------------------------------------------------------
// testbench: self-checking bench for msb_first_bit_packer
// Drives data, zero-run, flush and unused commands on the request stream,
// predicts every emitted byte with a bit-level packer model and checks each
// response beat in order, under random idling and long back-pressure.
// ---------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   // the command value the block ignores
   localparam mfbp_pkg::cmd_type CMD_UNUSED = 2'd3;

   typedef struct packed {
      logic [mfbp_pkg::BYTE_W-1:0]  data_byte;
      logic [mfbp_pkg::MBITS_W-1:0] n_valid;
      logic                         run_end;
   } byte_result_type;

   logic                             clock = 1'b0;
   logic                             reset;
   logic                             req_tvalid;
   logic                             req_tready;
   logic [mfbp_pkg::REQ_TDATA_W-1:0] req_tdata;   // chunk_word, bit_offset, bit_count
   logic [mfbp_pkg::REQ_TUSER_W-1:0] req_tuser;   // cmd
   logic                             rsp_tvalid;
   logic                             rsp_tready;
   logic [mfbp_pkg::RSP_TDATA_W-1:0] rsp_tdata;   // out_byte, meaningful_bits
   logic                             rsp_tlast;

   // packer model state
   logic [mfbp_pkg::BYTE_W-1:0] packer_byte;
   int                          packer_fill;
   byte_result_type             expected_bytes[$];

   int error_count   = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_off_left = 0;

   msb_first_bit_packer u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always #5 clock = ~clock;

   // Pack the bits of one accepted request and queue the bytes it completes.
   task automatic predict_request(input mfbp_pkg::cmd_type cmd,
                                  input logic [mfbp_pkg::WORD_BITS-1:0] word,
                                  input logic [mfbp_pkg::OFFSET_W-1:0] offset,
                                  input logic [mfbp_pkg::COUNT_W-1:0] count);
      int              n_bits;
      int              n_out;
      int              i;
      logic            src_bit;
      byte_result_type run_buf [8];
      n_bits = 0;
      n_out  = 0;
      if (cmd == mfbp_pkg::CMD_APPEND_DATA) begin
         n_bits = (int'(count) > mfbp_pkg::WORD_BITS - int'(offset)) ?
                  mfbp_pkg::WORD_BITS - int'(offset) : int'(count);
      end else if (cmd == mfbp_pkg::CMD_APPEND_ZERO) begin
         n_bits = (int'(count) > mfbp_pkg::WORD_BITS) ? mfbp_pkg::WORD_BITS : int'(count);
      end
      // shift bits in MSB-first, emitting each full byte
      for (i = 0; i < n_bits; i++) begin
         src_bit = 1'b0;
         if (cmd == mfbp_pkg::CMD_APPEND_DATA)
            src_bit = word[mfbp_pkg::WORD_BITS - 1 - int'(offset) - i];
         packer_byte[7 - packer_fill] = src_bit;
         packer_fill++;
         if (packer_fill == mfbp_pkg::BYTE_W) begin
            run_buf[n_out] = '{packer_byte, mfbp_pkg::FULL_BYTE_BITS, 1'b0};
            n_out++;
            packer_byte = '0;
            packer_fill = 0;
         end
      end
      // flush the partial tail, zero-padded
      if (cmd == mfbp_pkg::CMD_FLUSH && packer_fill != 0) begin
         run_buf[n_out] = '{packer_byte, mfbp_pkg::MBITS_W'(packer_fill), 1'b0};
         n_out++;
         packer_byte = '0;
         packer_fill = 0;
      end
      if (n_out > 0)
         run_buf[n_out - 1].run_end = 1'b1;
      for (i = 0; i < n_out; i++)
         expected_bytes.push_back(run_buf[i]);
   endtask

   // Offer one request, hold it until taken, then predict its bytes.
   task automatic send_request(input mfbp_pkg::cmd_type cmd,
                               input logic [mfbp_pkg::WORD_BITS-1:0] word,
                               input logic [mfbp_pkg::OFFSET_W-1:0] offset,
                               input logic [mfbp_pkg::COUNT_W-1:0] count);
      while ($urandom_range(99) < send_idle_pct) begin
         @(negedge clock);
         req_tvalid = 1'b0;
      end
      @(negedge clock);
      req_tvalid = 1'b1;
      req_tuser  = cmd;
      req_tdata  = mfbp_pkg::REQ_TDATA_W'({count, offset, word});
      do
         @(posedge clock);
      while (!req_tready);
      predict_request(cmd, word, offset, count);
   endtask

   // Pause the sender until every expected byte has come out.
   task automatic wait_for_drain();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (expected_bytes.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic test_directed();
      send_request(mfbp_pkg::CMD_APPEND_DATA, 64'hFFFF_FFFF_FFFF_FFFF, 6'd0, 7'd64);
      send_request(mfbp_pkg::CMD_APPEND_DATA, 64'hA000_0000_0000_0001, 6'd0, 7'd3);
      send_request(mfbp_pkg::CMD_FLUSH, 64'h0, 6'd0, 7'd0);
      // flush with nothing pending
      send_request(mfbp_pkg::CMD_FLUSH, 64'hFFFF_FFFF_FFFF_FFFF, 6'd63, 7'd127);
      // zero count on both append commands
      send_request(mfbp_pkg::CMD_APPEND_DATA, 64'hFFFF_FFFF_FFFF_FFFF, 6'd5, 7'd0);
      send_request(mfbp_pkg::CMD_APPEND_ZERO, 64'h0, 6'd0, 7'd0);
      // clipped data counts
      send_request(mfbp_pkg::CMD_APPEND_DATA, 64'h0000_0000_0000_0001, 6'd63, 7'd64);
      send_request(mfbp_pkg::CMD_APPEND_DATA, 64'h5555_5555_5555_555A, 6'd60, 7'd127);
      // clipped zero run, offset ignored
      send_request(mfbp_pkg::CMD_APPEND_ZERO, 64'hFFFF_FFFF_FFFF_FFFF, 6'd63, 7'd127);
      send_request(mfbp_pkg::CMD_APPEND_ZERO, 64'h0, 6'd17, 7'd3);
      send_request(CMD_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF, 6'd63, 7'd127);
      send_request(mfbp_pkg::CMD_APPEND_DATA, 64'hA5A5_A5A5_A5A5_A5A5, 6'd5, 7'd59);
      send_request(mfbp_pkg::CMD_APPEND_DATA, 64'h0, 6'd0, 7'd64);
      send_request(mfbp_pkg::CMD_APPEND_DATA, 64'h0123_4567_89AB_CDEF, 6'd32, 7'd32);
      send_request(mfbp_pkg::CMD_APPEND_DATA, 64'hFE00_0000_0000_0000, 6'd0, 7'd7);
      send_request(mfbp_pkg::CMD_FLUSH, 64'h0, 6'd0, 7'd0);
      send_request(mfbp_pkg::CMD_APPEND_ZERO, 64'h0, 6'd0, 7'd1);
      send_request(mfbp_pkg::CMD_FLUSH, 64'h0, 6'd0, 7'd0);
      send_request(mfbp_pkg::CMD_APPEND_DATA, 64'hFFFF_FFFF_FFFF_FFFF, 6'd63, 7'd1);
      send_request(mfbp_pkg::CMD_APPEND_DATA, 64'hFFFF_FFFF_FFFF_FFFF, 6'd1, 7'd64);
      send_request(mfbp_pkg::CMD_APPEND_ZERO, 64'h0, 6'd0, 7'd64);
      send_request(mfbp_pkg::CMD_FLUSH, 64'h0, 6'd0, 7'd0);
   endtask

   task automatic test_random(input int n_items);
      int                             sent;
      int                             pick;
      mfbp_pkg::cmd_type              cmd;
      logic [mfbp_pkg::WORD_BITS-1:0] word;
      logic [mfbp_pkg::OFFSET_W-1:0]  offset;
      logic [mfbp_pkg::COUNT_W-1:0]   count;
      sent = 0;
      while (sent < n_items) begin
         pick = $urandom_range(99);
         if (pick < 55)      cmd = mfbp_pkg::CMD_APPEND_DATA;
         else if (pick < 72) cmd = mfbp_pkg::CMD_APPEND_ZERO;
         else if (pick < 95) cmd = mfbp_pkg::CMD_FLUSH;
         else                cmd = CMD_UNUSED;
         word   = {$urandom, $urandom};
         offset = ($urandom_range(2) == 0) ? mfbp_pkg::OFFSET_W'($urandom_range(63))
                                           : mfbp_pkg::OFFSET_W'($urandom_range(12));
         pick = $urandom_range(99);
         if (pick < 70)      count = mfbp_pkg::COUNT_W'($urandom_range(16));
         else if (pick < 90) count = mfbp_pkg::COUNT_W'($urandom_range(64, 17));
         else                count = mfbp_pkg::COUNT_W'($urandom_range(127, 65));
         send_request(cmd, word, offset, count);
         sent++;
      end
   endtask

   // Hold the response side off while full chunks keep arriving.
   task automatic test_backpressure();
      int i;
      hold_off_left = 200;
      for (i = 0; i < 24; i++)
         send_request(mfbp_pkg::CMD_APPEND_DATA, {$urandom, $urandom}, 6'd0, 7'd64);
      wait_for_drain();
   endtask

   // Response side: random ready, with an optional long hold-off.
   always @(negedge clock) begin
      if (hold_off_left > 0) begin
         rsp_tready    = 1'b0;
         hold_off_left = hold_off_left - 1;
      end else begin
         rsp_tready = ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Compare each response with the oldest expected byte.
   always @(posedge clock) begin
      byte_result_type exp_b;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_bytes.size() == 0) begin
            $display("%0t: unexpected response: expected none, actual byte %02h bits %0d",
                     $time, rsp_tdata[7:0], rsp_tdata[11:8]);
            error_count++;
         end else begin
            exp_b = expected_bytes.pop_front();
            if (rsp_tdata[7:0] !== exp_b.data_byte) begin
               $display("%0t: out_byte mismatch: expected %02h, actual %02h",
                        $time, exp_b.data_byte, rsp_tdata[7:0]);
               error_count++;
            end
            if (rsp_tdata[11:8] !== exp_b.n_valid) begin
               $display("%0t: meaningful_bits mismatch: expected %0d, actual %0d",
                        $time, exp_b.n_valid, rsp_tdata[11:8]);
               error_count++;
            end
            if (rsp_tlast !== exp_b.run_end) begin
               $display("%0t: last_of_run mismatch: expected %0b, actual %0b",
                        $time, exp_b.run_end, rsp_tlast);
               error_count++;
            end
         end
      end
   end

   initial begin
      #3_000_000;
      $display("*** FAILED ***");
      $finish;
   end

   initial begin
      int wait_cycles;
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = '0;
      packer_byte = '0;
      packer_fill = 0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // sender mostly busy, receiver often stalled
      send_idle_pct = 9;
      recv_idle_pct = 55;
      test_directed();
      test_random(125);
      wait_for_drain();

      // sender often idle, receiver mostly ready
      send_idle_pct = 55;
      recv_idle_pct = 9;
      test_random(125);
      wait_for_drain();

      // no idling on either side
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_backpressure();
      test_random(114);

      // drain what is left, then let the pipeline settle
      @(negedge clock);
      req_tvalid  = 1'b0;
      wait_cycles = 0;
      while (expected_bytes.size() != 0 && wait_cycles < 5000) begin
         @(posedge clock);
         wait_cycles++;
      end
      if (expected_bytes.size() != 0) begin
         $display("%0t: %0d expected bytes never arrived, next expected %02h",
                  $time, expected_bytes.size(), expected_bytes[0].data_byte);
         error_count++;
      end
      repeat (20) @(posedge clock);
      if (error_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
